// ===== hdl/chkg_pkg.sv =====
// ----------------------------------------------------------------------------
// chkg_pkg
// Shared types, constants and the quarter-round function of the ChaCha
// keystream generator.
// ----------------------------------------------------------------------------
package chkg_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [15:0] block_t;

  localparam word_t SIGMA_0 = 32'h6578_7061;
  localparam word_t SIGMA_1 = 32'h6E64_2033;
  localparam word_t SIGMA_2 = 32'h322D_6279;
  localparam word_t SIGMA_3 = 32'h7465_206B;

  localparam int REQ_QUEUE_DEPTH = 4;
  localparam int REQ_CNT_W       = $clog2(REQ_QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE = 3'd4;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  typedef struct packed {
    logic   start;
    block_t init;
  } core_req_t;

  typedef struct packed {
    logic   done;
    block_t sum;
  } core_rsp_t;

  typedef enum logic {
    BK_SERVE,
    BK_BUILD
  } back_state_e;

  function automatic word_t chkg_rotl(word_t x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic qr_t chkg_qr(word_t a_in, word_t b_in, word_t c_in, word_t d_in);
    qr_t r;
    r.a = a_in + b_in;
    r.d = chkg_rotl(d_in ^ r.a, 16);
    r.c = c_in + r.d;
    r.b = chkg_rotl(b_in ^ r.c, 12);
    r.a = r.a + r.b;
    r.d = chkg_rotl(r.d ^ r.a, 8);
    r.c = r.c + r.d;
    r.b = chkg_rotl(r.b ^ r.c, 7);
    return r;
  endfunction

endpackage

// ===== hdl/chacha_keystream_generator_unit.sv =====
// Flow: a request is counted in the front queue; while a block is buffered,
// the back end then loads the next word into the output register. A request
// that finds the buffer empty waits for the round engine, one ChaCha round
// per cycle, to build a block. Each block yields 8 words.
// Reset: rst_ni asynchronous, clears the request queue, the counter, keys,
// nonce and the buffer-full flag; the first request builds a block.
// ----------------------------------------------------------------------------
// chacha_keystream_generator_unit
// ChaCha-based random word source: request queue, block builder and buffer.
// ----------------------------------------------------------------------------
module chacha_keystream_generator_unit import chkg_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [63:0]          cfg_wdata_i,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [0] take, [7:1] zero
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [63:0]          m_axis_tdata_o    // [63:0] value
);

  logic      req_pending, req_pop;
  core_req_t core_req;
  core_rsp_t core_rsp;

  chkg_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .req_pending_o (req_pending),
    .req_pop_i     (req_pop)
  );

  chkg_core #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_core (
    .clk_i,
    .rst_ni,
    .req_i (core_req),
    .rsp_o (core_rsp)
  );

  chkg_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .req_pending_i (req_pending),
    .req_pop_o     (req_pop),
    .core_req_o    (core_req),
    .core_rsp_i    (core_rsp),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

endmodule

// ===== hdl/chkg_front.sv =====
// ----------------------------------------------------------------------------
// chkg_front
// Takes request words, drops those without the take flag and keeps a short
// token queue of pending requests for the back end.
// ----------------------------------------------------------------------------
module chkg_front import chkg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [0] take, [7:1] zero
  output logic       req_pending_o,
  input  logic       req_pop_i
);

  logic [REQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                 push;

  assign s_axis_tready_o = (cnt_q != REQ_CNT_W'(REQ_QUEUE_DEPTH));
  assign push            = s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[0];
  assign req_pending_o   = (cnt_q != '0);

  always_comb begin
    unique case ({push, req_pop_i})
      2'b10:   cnt_d = cnt_q + REQ_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - REQ_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hdl/chkg_core.sv =====
// ----------------------------------------------------------------------------
// chkg_core
// ChaCha round engine: four quarter-rounds per cycle, column and diagonal
// rounds alternating, then feed-forward sum of the initial state.
// ----------------------------------------------------------------------------
module chkg_core import chkg_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  core_req_t req_i,
  output core_rsp_t rsp_o
);

  localparam int            CW   = $clog2(2 * DOUBLE_ROUNDS);
  localparam logic [CW-1:0] LAST = CW'(2 * DOUBLE_ROUNDS - 1);

  logic          busy_q, done_q;
  logic [CW-1:0] rnd_q;
  block_t        work_q, init_q, rnd_res;
  qr_t [3:0]     col_res, dia_res;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam int DB = 4 + ((l + 1) % 4);
    localparam int DC = 8 + ((l + 2) % 4);
    localparam int DD = 12 + ((l + 3) % 4);
    assign col_res[l] = chkg_qr(work_q[l], work_q[4+l], work_q[8+l], work_q[12+l]);
    assign dia_res[l] = chkg_qr(work_q[l], work_q[DB], work_q[DC], work_q[DD]);
  end

  always_comb begin
    rnd_res = work_q;
    for (int l = 0; l < 4; l++) begin
      if (!rnd_q[0]) begin
        rnd_res[l]      = col_res[l].a;
        rnd_res[4 + l]  = col_res[l].b;
        rnd_res[8 + l]  = col_res[l].c;
        rnd_res[12 + l] = col_res[l].d;
      end else begin
        rnd_res[l]                    = dia_res[l].a;
        rnd_res[4 + ((l + 1) & 3)]    = dia_res[l].b;
        rnd_res[8 + ((l + 2) & 3)]    = dia_res[l].c;
        rnd_res[12 + ((l + 3) & 3)]   = dia_res[l].d;
      end
    end
  end

  always_comb begin
    rsp_o.done = done_q;
    for (int i = 0; i < 16; i++) begin
      rsp_o.sum[i] = work_q[i] + init_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + CW'(1);
        if (rnd_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      work_q <= req_i.init;
      init_q <= req_i.init;
    end else if (busy_q) begin
      work_q <= rnd_res;
    end
  end

endmodule

// ===== hdl/chkg_back.sv =====
// ----------------------------------------------------------------------------
// chkg_back
// Key and nonce registers, block counter, block buffer and output register.
// Serves queued requests from the buffer and refills it through the core.
// ----------------------------------------------------------------------------
module chkg_back import chkg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_addr_i,
  input  logic [63:0]          cfg_wdata_i,
  input  logic                 req_pending_i,
  output logic                 req_pop_o,
  output core_req_t            core_req_o,
  input  core_rsp_t            core_rsp_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [63:0]          m_axis_tdata_o    // [63:0] value
);

  back_state_e      state_q, state_d;
  logic [3:0][63:0] key_q;
  logic [63:0]      nonce_q, blk_cnt_q;
  logic             full_q, out_valid_q;
  logic [2:0]       pos_q;
  logic [63:0]      pair_q [8];
  logic [63:0]      out_data_q;
  logic             out_free, load_out, fill, start;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign req_pop_o       = load_out;

  always_comb begin
    core_req_o.start     = start;
    core_req_o.init[0]   = SIGMA_0;
    core_req_o.init[1]   = SIGMA_1;
    core_req_o.init[2]   = SIGMA_2;
    core_req_o.init[3]   = SIGMA_3;
    for (int k = 0; k < 4; k++) begin
      core_req_o.init[4 + 2*k] = key_q[k][63:32];
      core_req_o.init[5 + 2*k] = key_q[k][31:0];
    end
    core_req_o.init[12]  = blk_cnt_q[63:32];
    core_req_o.init[13]  = blk_cnt_q[31:0];
    core_req_o.init[14]  = nonce_q[63:32];
    core_req_o.init[15]  = nonce_q[31:0];
  end

  always_comb begin
    state_d  = state_q;
    start    = 1'b0;
    load_out = 1'b0;
    fill     = 1'b0;
    unique case (state_q)
      BK_SERVE: begin
        if (req_pending_i) begin
          if (full_q) begin
            load_out = out_free;
          end else begin
            start   = 1'b1;
            state_d = BK_BUILD;
          end
        end
      end
      BK_BUILD: begin
        if (core_rsp_i.done) begin
          fill    = 1'b1;
          state_d = BK_SERVE;
        end
      end
      default: state_d = BK_SERVE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_SERVE;
      key_q       <= '0;
      nonce_q     <= '0;
      blk_cnt_q   <= '0;
      full_q      <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_KEY_0: key_q[0] <= cfg_wdata_i;
          CFG_KEY_1: key_q[1] <= cfg_wdata_i;
          CFG_KEY_2: key_q[2] <= cfg_wdata_i;
          CFG_KEY_3: key_q[3] <= cfg_wdata_i;
          CFG_NONCE: nonce_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (fill) begin
        full_q    <= 1'b1;
        pos_q     <= '0;
        blk_cnt_q <= blk_cnt_q + 64'd1;
      end else if (load_out) begin
        pos_q <= pos_q + 3'd1;
        if (pos_q == 3'd7) begin
          full_q <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill) begin
      for (int i = 0; i < 8; i++) begin
        pair_q[i] <= {core_rsp_i.sum[2*i], core_rsp_i.sum[2*i + 1]};
      end
    end
    if (load_out) begin
      out_data_q <= pair_q[pos_q];
    end
  end

endmodule

// ===== hdl/chkg_checker.sv =====
// ----------------------------------------------------------------------------
// chkg_checker
// Port-level checks for the ChaCha keystream generator.
// ----------------------------------------------------------------------------
module chkg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  a_reset_out: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("output valid after reset");

  a_reset_ready: assert property (@(posedge clk_i)
    !rst_ni |=> s_axis_tready_o)
    else $error("input not ready after reset");

  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> $past(!s_axis_tready_o) ||
      $past(s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[0]))
    else $error("request queue filled without a request");

endmodule

bind chacha_keystream_generator_unit chkg_checker u_chkg_checker (.*);
